FILE: src/tsvf_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and control/status structs of the time source vote filter
package tsvf_pkg;

  localparam int unsigned MAX_CAND   = 8;
  localparam int unsigned CIDX_W     = $clog2(MAX_CAND);
  localparam int unsigned FILL_W     = $clog2(MAX_CAND + 1);

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned DRIFT_W    = 16;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned AGE_W      = 32;
  localparam int unsigned MINC_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [DRIFT_W-1:0] DRIFT_RST   = 16'd2000;
  localparam logic [TOL_W-1:0]   TOL_RST     = 16'd100;
  localparam logic [AGE_W-1:0]   MAX_AGE_RST = 32'd86400000;
  localparam logic [MINC_W-1:0]  MINC_RST    = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT = 3'd0,
    CMD_FORCE  = 3'd1,
    CMD_VOTE   = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_CLEAR  = 3'd4
  } tsvf_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK      = 3'd0,
    STS_QUEUED  = 3'd1,
    STS_FULL    = 3'd2,
    STS_TOO_FEW = 3'd3,
    STS_NO_MAJ  = 3'd4,
    STS_NO_TIME = 3'd5
  } tsvf_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIFT   = 2'd0,
    CFG_TOL     = 2'd1,
    CFG_MAX_AGE = 2'd2,
    CFG_MIN_CAND = 2'd3
  } tsvf_cfg_e;

  // operand source of the projection pipeline
  typedef enum logic [1:0] {
    SRC_PAIR   = 2'd0,
    SRC_SUBMIT = 2'd1,
    SRC_QUERY  = 2'd2,
    SRC_PICK   = 2'd3
  } tsvf_src_e;

  typedef struct packed {
    logic              in_load;
    logic              op_load;
    logic              issue;
    tsvf_src_e         src;
    logic [CIDX_W-1:0] idx_a;
    logic [CIDX_W-1:0] idx_b;
    logic              last;
    logic              vote_init;
    logic              adopt_sample;
    logic              adopt_pick;
    logic              drop_trust;
    logic              enq;
    logic              clear_fill;
    logic              out_load;
    tsvf_status_e      status;
  } tsvf_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              present;
    logic              full;
    logic              empty;
    logic              too_few;
    logic              busy;
    logic              res_valid;
    logic              age_ok;
    logic              drift_ok;
    logic              best_zero;
    logic [CIDX_W-1:0] last_idx;
  } tsvf_sts_t;

endpackage

FILE: src/tsvf_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for command items and result items
interface tsvf_in_if import tsvf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TIME_W-1:0] sample_time_ms;
  logic [TIME_W-1:0] sample_boot_ms;
  logic [TIME_W-1:0] now_boot_ms;

  modport source (output valid, output command, output sample_time_ms,
                  output sample_boot_ms, output now_boot_ms, input ready);
  modport sink (input valid, input command, input sample_time_ms,
                input sample_boot_ms, input now_boot_ms, output ready);
endinterface

interface tsvf_out_if import tsvf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TIME_W-1:0] current_time_ms;
  logic              time_valid;
  logic [CNT_W-1:0]  candidate_count;

  modport source (output valid, output status, output current_time_ms,
                  output time_valid, output candidate_count, input ready);
  modport sink (input valid, input status, input current_time_ms,
                input time_valid, input candidate_count, output ready);
endinterface

FILE: src/tsvf_dp.sv
`timescale 1ns / 1ps
// datapath: config, trusted pair, candidate memory, projection pipeline, vote tally
module tsvf_dp import tsvf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [TIME_W-1:0]     sample_time_ms_i,
  input  logic [TIME_W-1:0]     sample_boot_ms_i,
  input  logic [TIME_W-1:0]     now_boot_ms_i,
  input  tsvf_ctl_t             ctl_i,
  output tsvf_sts_t             sts_o,
  output logic [STAT_W-1:0]     status_o,
  output logic [TIME_W-1:0]     current_time_ms_o,
  output logic                  time_valid_o,
  output logic [CNT_W-1:0]      candidate_count_o
);

  localparam int unsigned DW = TIME_W + 1;
  localparam int unsigned SW = TIME_W + 2;

  // configuration
  logic [DRIFT_W-1:0] drift_q;
  logic [TOL_W-1:0]   tol_q;
  logic [AGE_W-1:0]   max_age_q;
  logic [MINC_W-1:0]  minc_q;

  // accepted item
  logic [CMD_W-1:0]  cmd_q;
  logic [TIME_W-1:0] swall_q, sboot_q, nboot_q;

  // trusted pair and candidate list
  logic [TIME_W-1:0] twall_q, tboot_q;
  logic              present_q;
  logic [FILL_W-1:0] fill_q;
  logic [TIME_W-1:0] cw_mem [MAX_CAND];
  logic [TIME_W-1:0] cb_mem [MAX_CAND];

  // pipeline
  logic [TIME_W-1:0]    oaw_q, oab_q, obw_q, obb_q;
  logic                 v0_q, v1_q, v2_q, v3_q;
  logic                 pr0_q, pr1_q, pr2_q, pr3_q;
  logic                 lt0_q, lt1_q, lt2_q, lt3_q;
  logic [CIDX_W-1:0]    ri0_q, ri1_q, ri2_q, ri3_q;
  logic signed [DW-1:0] age_d, gap_d, age1_q, gap1_q;
  logic                 aok_d, aok1_q, aok2_q, aok3_q;
  logic signed [SW-1:0] sum_d, sum2_q, sum3_q;
  logic [SW-1:0]        mag_d;
  logic                 dok3_q, tok3_q;

  // vote tally
  logic [FILL_W-1:0] vcnt_q, best_q, cnt_new;
  logic [CIDX_W-1:0] bidx_q;
  logic              hit, maj;

  logic [TIME_W-1:0] clamp;

  logic [STAT_W-1:0] ost_q;
  logic [TIME_W-1:0] ocur_q;
  logic              otv_q;
  logic [CNT_W-1:0]  ocnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drift_q   <= DRIFT_RST;
      tol_q     <= TOL_RST;
      max_age_q <= MAX_AGE_RST;
      minc_q    <= MINC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DRIFT:    drift_q   <= cfg_data_i[DRIFT_W-1:0];
        CFG_TOL:      tol_q     <= cfg_data_i[TOL_W-1:0];
        CFG_MAX_AGE:  max_age_q <= cfg_data_i[AGE_W-1:0];
        CFG_MIN_CAND: minc_q    <= cfg_data_i[MINC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.in_load) begin
      cmd_q   <= command_i;
      swall_q <= sample_time_ms_i;
      sboot_q <= sample_boot_ms_i;
      nboot_q <= now_boot_ms_i;
    end
    if (ctl_i.adopt_sample) begin
      twall_q <= swall_q;
      tboot_q <= sboot_q;
    end else if (ctl_i.adopt_pick) begin
      twall_q <= oaw_q;
      tboot_q <= oab_q;
    end
    if (ctl_i.enq) begin
      cw_mem[fill_q[CIDX_W-1:0]] <= swall_q;
      cb_mem[fill_q[CIDX_W-1:0]] <= sboot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      fill_q    <= '0;
    end else begin
      if (ctl_i.adopt_sample || ctl_i.adopt_pick) begin
        present_q <= 1'b1;
      end else if (ctl_i.drop_trust) begin
        present_q <= 1'b0;
      end
      if (ctl_i.clear_fill) begin
        fill_q <= '0;
      end else if (ctl_i.enq) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // operand registers, memory read is registered here
  always_ff @(posedge clk_i) begin
    if (ctl_i.op_load) begin
      unique case (ctl_i.src)
        SRC_PAIR: begin
          oaw_q <= cw_mem[ctl_i.idx_a];
          oab_q <= cb_mem[ctl_i.idx_a];
          obw_q <= cw_mem[ctl_i.idx_b];
          obb_q <= cb_mem[ctl_i.idx_b];
        end
        SRC_SUBMIT: begin
          oaw_q <= swall_q;
          oab_q <= sboot_q;
          obw_q <= twall_q;
          obb_q <= tboot_q;
        end
        SRC_QUERY: begin
          oaw_q <= '0;
          oab_q <= nboot_q;
          obw_q <= twall_q;
          obb_q <= tboot_q;
        end
        SRC_PICK: begin
          oaw_q <= cw_mem[bidx_q];
          oab_q <= cb_mem[bidx_q];
          obw_q <= cw_mem[ctl_i.idx_b];
          obb_q <= cb_mem[ctl_i.idx_b];
        end
        default: ;
      endcase
      pr0_q <= (ctl_i.src == SRC_PAIR);
      lt0_q <= ctl_i.last;
      ri0_q <= ctl_i.idx_a;
    end
  end

  // age of b seen from a, gap of walls, and their sum: b projected minus a
  assign age_d = $signed({1'b0, oab_q}) - $signed({1'b0, obb_q});
  assign gap_d = $signed({1'b0, obw_q}) - $signed({1'b0, oaw_q});
  assign aok_d = age_d <= $signed({{(DW-AGE_W){1'b0}}, max_age_q});
  assign sum_d = {age1_q[DW-1], age1_q} + {gap1_q[DW-1], gap1_q};
  assign mag_d = sum2_q[SW-1] ? (~sum2_q + 1'b1) : sum2_q;

  always_ff @(posedge clk_i) begin
    age1_q <= age_d;
    gap1_q <= gap_d;
    aok1_q <= aok_d;
    pr1_q  <= pr0_q;
    lt1_q  <= lt0_q;
    ri1_q  <= ri0_q;
    sum2_q <= sum_d;
    aok2_q <= aok1_q;
    pr2_q  <= pr1_q;
    lt2_q  <= lt1_q;
    ri2_q  <= ri1_q;
    sum3_q <= sum2_q;
    aok3_q <= aok2_q;
    dok3_q <= mag_d <= {{(SW-DRIFT_W){1'b0}}, drift_q};
    tok3_q <= mag_d < {{(SW-TOL_W){1'b0}}, tol_q};
    pr3_q  <= pr2_q;
    lt3_q  <= lt2_q;
    ri3_q  <= ri2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= ctl_i.issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign hit     = aok3_q & tok3_q;
  assign cnt_new = vcnt_q + FILL_W'(hit);
  assign maj     = cnt_new > (fill_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
      best_q <= '0;
      bidx_q <= '0;
    end else if (ctl_i.vote_init) begin
      vcnt_q <= '0;
      best_q <= '0;
    end else if (v3_q && pr3_q) begin
      if (lt3_q) begin
        vcnt_q <= '0;
        // first row with the highest majority count wins
        if (maj && (cnt_new > best_q)) begin
          best_q <= cnt_new;
          bidx_q <= ri3_q;
        end
      end else begin
        vcnt_q <= cnt_new;
      end
    end
  end

  always_comb begin
    if (sum3_q[SW-1]) begin
      clamp = '0;
    end else if (sum3_q[SW-2]) begin
      clamp = '1;
    end else begin
      clamp = sum3_q[TIME_W-1:0];
    end
  end

  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.present   = present_q;
    sts_o.full      = (fill_q == FILL_W'(MAX_CAND));
    sts_o.empty     = (fill_q == '0);
    sts_o.too_few   = {{MINC_W{1'b0}}, fill_q} < {{FILL_W{1'b0}}, minc_q};
    sts_o.busy      = v0_q | v1_q | v2_q | v3_q;
    sts_o.res_valid = v3_q;
    sts_o.age_ok    = aok3_q;
    sts_o.drift_ok  = dok3_q;
    sts_o.best_zero = (best_q == '0);
    sts_o.last_idx  = CIDX_W'(fill_q - 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      ost_q  <= ctl_i.status;
      ocur_q <= ((cmd_q == CMD_QUERY) && (ctl_i.status == STS_OK)) ? clamp : '0;
      otv_q  <= present_q;
      ocnt_q <= CNT_W'(fill_q);
    end
  end

  assign status_o          = ost_q;
  assign current_time_ms_o = ocur_q;
  assign time_valid_o      = otv_q;
  assign candidate_count_o = ocnt_q;

  a_enq_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.enq |-> (fill_q < FILL_W'(MAX_CAND)))
    else $error("candidate written while list full");

  a_single_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.issue && (ctl_i.src != SRC_PAIR)) |-> !sts_o.busy)
    else $error("projection issued into a busy pipeline");

  a_pick_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.adopt_pick |-> $past(ctl_i.op_load && (ctl_i.src == SRC_PICK)))
    else $error("vote winner adopted without its read");

  a_adopt_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.adopt_sample || ctl_i.adopt_pick) |=> present_q)
    else $error("adopted time not marked valid");

  a_out_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> !sts_o.busy)
    else $error("result loaded while pipeline still busy");

endmodule

FILE: src/tsvf_ctrl.sv
`timescale 1ns / 1ps
// controller: command sequencing, vote pair scan and result handshake
module tsvf_ctrl import tsvf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  tsvf_sts_t sts_i,
  output tsvf_ctl_t ctl_o
);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_DECODE     = 4'd1;
  localparam logic [3:0] ST_WAIT_PROJ  = 4'd2;
  localparam logic [3:0] ST_ENQ        = 4'd3;
  localparam logic [3:0] ST_VOTE_ISSUE = 4'd4;
  localparam logic [3:0] ST_VOTE_DRAIN = 4'd5;
  localparam logic [3:0] ST_VOTE_PICK  = 4'd6;
  localparam logic [3:0] ST_VOTE_ADOPT = 4'd7;
  localparam logic [3:0] ST_RESP       = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [CIDX_W-1:0] ia_q, ia_d, ib_q, ib_d;
  tsvf_status_e      status_q, status_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    ia_d         = ia_q;
    ib_d         = ib_q;
    status_d     = status_q;
    ctl_o        = '0;
    ctl_o.src    = SRC_PAIR;
    ctl_o.idx_a  = ia_q;
    ctl_o.idx_b  = ib_q;
    ctl_o.status = status_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.in_load = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.cmd)
          CMD_SUBMIT: begin
            if (sts_i.present) begin
              ctl_o.op_load = 1'b1;
              ctl_o.issue   = 1'b1;
              ctl_o.src     = SRC_SUBMIT;
              state_d       = ST_WAIT_PROJ;
            end else begin
              state_d = ST_ENQ;
            end
          end
          CMD_FORCE: begin
            ctl_o.adopt_sample = 1'b1;
            status_d           = STS_OK;
            state_d            = ST_RESP;
          end
          CMD_VOTE: begin
            if (sts_i.too_few) begin
              status_d = STS_TOO_FEW;
              state_d  = ST_RESP;
            end else if (sts_i.empty) begin
              // zero minimum with an empty list: nothing to scan, no majority
              status_d = STS_NO_MAJ;
              state_d  = ST_RESP;
            end else begin
              ctl_o.vote_init = 1'b1;
              ia_d            = '0;
              ib_d            = '0;
              state_d         = ST_VOTE_ISSUE;
            end
          end
          CMD_QUERY: begin
            if (sts_i.present) begin
              ctl_o.op_load = 1'b1;
              ctl_o.issue   = 1'b1;
              ctl_o.src     = SRC_QUERY;
              state_d       = ST_WAIT_PROJ;
            end else begin
              status_d = STS_NO_TIME;
              state_d  = ST_RESP;
            end
          end
          CMD_CLEAR: begin
            ctl_o.clear_fill = 1'b1;
            status_d         = STS_OK;
            state_d          = ST_RESP;
          end
          default: begin
            status_d = STS_OK;
            state_d  = ST_RESP;
          end
        endcase
      end
      ST_WAIT_PROJ: begin
        if (sts_i.res_valid) begin
          if (sts_i.cmd == CMD_QUERY) begin
            if (sts_i.age_ok) begin
              status_d = STS_OK;
            end else begin
              ctl_o.drop_trust = 1'b1;
              status_d         = STS_NO_TIME;
            end
            state_d = ST_RESP;
          end else if (!sts_i.age_ok) begin
            // trusted time has expired: drop it and queue the sample if there is room
            ctl_o.drop_trust = 1'b1;
            state_d          = ST_ENQ;
          end else if (!sts_i.drift_ok) begin
            state_d = ST_ENQ;
          end else begin
            ctl_o.adopt_sample = 1'b1;
            ctl_o.clear_fill   = 1'b1;
            status_d           = STS_OK;
            state_d            = ST_RESP;
          end
        end
      end
      ST_ENQ: begin
        if (sts_i.full) begin
          status_d = STS_FULL;
        end else begin
          ctl_o.enq = 1'b1;
          status_d  = STS_QUEUED;
        end
        state_d = ST_RESP;
      end
      ST_VOTE_ISSUE: begin
        // one candidate pair per cycle, row by row
        ctl_o.op_load = 1'b1;
        ctl_o.issue   = 1'b1;
        ctl_o.src     = SRC_PAIR;
        ctl_o.last    = (ib_q == sts_i.last_idx);
        if (ib_q == sts_i.last_idx) begin
          ib_d = '0;
          if (ia_q == sts_i.last_idx) begin
            state_d = ST_VOTE_DRAIN;
          end else begin
            ia_d = ia_q + 1'b1;
          end
        end else begin
          ib_d = ib_q + 1'b1;
        end
      end
      ST_VOTE_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = ST_VOTE_PICK;
        end
      end
      ST_VOTE_PICK: begin
        ctl_o.clear_fill = 1'b1;
        if (sts_i.best_zero) begin
          status_d = STS_NO_MAJ;
          state_d  = ST_RESP;
        end else begin
          ctl_o.op_load = 1'b1;
          ctl_o.src     = SRC_PICK;
          state_d       = ST_VOTE_ADOPT;
        end
      end
      ST_VOTE_ADOPT: begin
        ctl_o.adopt_pick = 1'b1;
        status_d         = STS_OK;
        state_d          = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ia_q        <= '0;
      ib_q        <= '0;
      status_q    <= STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/time_source_vote_filter.sv
`timescale 1ns / 1ps
// top level: trusted time keeper with candidate voting, controller plus datapath
// force, clear, unknown commands, refused and empty votes answer without a projection;
// query and a submit with a trusted time pass through the four-stage projection pipeline
// a vote projects every ordered pair of candidates, then reads and adopts any winner
// one command at a time; next input transfer the cycle after the result is loaded
// async active-low reset: no trusted time, empty list, registers at defaults, no clear pass
module time_source_vote_filter import tsvf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tsvf_in_if.sink               in_i,
  tsvf_out_if.source            out_o
);

  tsvf_ctl_t ctl;
  tsvf_sts_t sts;

  tsvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  tsvf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .command_i         (in_i.command),
    .sample_time_ms_i  (in_i.sample_time_ms),
    .sample_boot_ms_i  (in_i.sample_boot_ms),
    .now_boot_ms_i     (in_i.now_boot_ms),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .status_o          (out_o.status),
    .current_time_ms_o (out_o.current_time_ms),
    .time_valid_o      (out_o.time_valid),
    .candidate_count_o (out_o.candidate_count)
  );

endmodule
